// ===== src/ffs_pkg.sv =====
package ffs_pkg;

  // Width of the line length counters; they saturate at their maximum.
  localparam int LINE_LEN_BITS = 16;
  localparam logic [LINE_LEN_BITS-1:0] LEN_MAX = {LINE_LEN_BITS{1'b1}};

  localparam logic [7:0] CH_EOL   = 8'h0A;
  localparam logic [7:0] CH_FASTA = 8'h3E;  // '>'
  localparam logic [7:0] CH_FASTQ = 8'h40;  // '@'
  localparam logic [7:0] CH_SEP   = 8'h2B;  // '+'

  localparam logic [2:0] V_FASTA = 3'd0;
  localparam logic [2:0] V_FASTQ = 3'd1;
  localparam logic [2:0] V_MULTI = 3'd2;
  localparam logic [2:0] V_NONE  = 3'd3;
  localparam logic [2:0] V_CUT   = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
  } ffs_item_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] verdict;
  } ffs_result_t;

endpackage

// ===== src/fasta_fastq_format_sniffer.sv =====
// Sniffs whether a text buffer holds FASTA, multi-line FASTA or FASTQ. Bytes
// arrive one word per cycle, while in_ready is high, with first and last
// marks; one verdict word is produced per buffer (0 fasta, 1 fastq, 2
// multi-line fasta, 3 not recognized, 4 fastq cut inside the read line),
// after which bytes are dropped until the next first mark. The block takes
// one byte every cycle unless a verdict waits with out_ready low; the byte
// that decides a verdict passes the input register, the combinational
// decision logic and the result register. Line lengths saturate at 2^16-1.
module fasta_fastq_format_sniffer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_first_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_verdict
);

  ffs_pkg::ffs_item_t   in_item_r;
  logic                 in_valid_r;
  logic                 out_valid_r;
  logic [2:0]           out_verdict_r;
  logic                 step;
  ffs_pkg::ffs_result_t res;

  // A held word moves on whenever the result register is free or draining.
  assign step     = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r.data_byte  <= in_data_byte;
      in_item_r.first_byte <= in_first_byte;
      in_item_r.last_byte  <= in_last_byte;
    end
  end

  ffs_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (in_item_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (res.valid) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_verdict_r <= res.verdict;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

endmodule

// ===== src/ffs_engine.sv =====
module ffs_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  ffs_pkg::ffs_item_t item,
  output ffs_pkg::ffs_result_t res
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TAG,
    PH_READ,
    PH_AFTER,
    PH_REMARK,
    PH_QUAL
  } phase_t;

  phase_t                              phase_r, phase_nxt;
  logic                                expect_quals_r, expect_quals_nxt;
  logic [ffs_pkg::LINE_LEN_BITS-1:0]   read_count_r, read_count_nxt;
  logic [ffs_pkg::LINE_LEN_BITS-1:0]   qual_count_r, qual_count_nxt;
  logic                                hit;
  logic [2:0]                          verdict;

  function automatic logic is_iupac(input logic [7:0] b);
    logic [7:0] u;
    logic       ok;
    u = (b >= 8'h61 && b <= 8'h7A) ? b - 8'd32 : b;
    case (u)
      8'h41, 8'h43, 8'h47, 8'h54, 8'h55, 8'h52, 8'h59, 8'h53,
      8'h57, 8'h4B, 8'h4D, 8'h42, 8'h44, 8'h48, 8'h56, 8'h4E: ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic [ffs_pkg::LINE_LEN_BITS-1:0] sat_inc(
      input logic [ffs_pkg::LINE_LEN_BITS-1:0] c);
    return (c == ffs_pkg::LEN_MAX) ? c : c + 1'b1;
  endfunction

  always_comb begin
    phase_nxt        = phase_r;
    expect_quals_nxt = expect_quals_r;
    read_count_nxt   = read_count_r;
    qual_count_nxt   = qual_count_r;
    hit              = 1'b0;
    verdict          = ffs_pkg::V_NONE;

    if (item.first_byte) begin
      read_count_nxt = '0;
      qual_count_nxt = '0;
      if (item.data_byte == ffs_pkg::CH_FASTA) begin
        expect_quals_nxt = 1'b0;
        phase_nxt        = PH_TAG;
      end else if (item.data_byte == ffs_pkg::CH_FASTQ) begin
        expect_quals_nxt = 1'b1;
        phase_nxt        = PH_TAG;
      end else begin
        expect_quals_nxt = 1'b0;
        phase_nxt        = PH_IDLE;
        hit              = 1'b1;
      end
    end else begin
      case (phase_r)
        PH_TAG: begin
          if (item.data_byte == ffs_pkg::CH_EOL) begin
            phase_nxt      = PH_READ;
            read_count_nxt = '0;
          end
        end
        PH_READ: begin
          if (item.data_byte == ffs_pkg::CH_EOL) begin
            phase_nxt = PH_AFTER;
          end else if (!is_iupac(item.data_byte)) begin
            hit = 1'b1;
          end else begin
            read_count_nxt = sat_inc(read_count_r);
          end
        end
        PH_AFTER: begin
          hit = 1'b1;
          if (item.data_byte == ffs_pkg::CH_SEP) begin
            if (expect_quals_r) begin
              hit       = 1'b0;
              phase_nxt = PH_REMARK;
            end
          end else if (item.data_byte == ffs_pkg::CH_FASTA) begin
            verdict = expect_quals_r ? ffs_pkg::V_NONE : ffs_pkg::V_FASTA;
          end else if (!expect_quals_r && is_iupac(item.data_byte)) begin
            verdict = ffs_pkg::V_MULTI;
          end
        end
        PH_REMARK: begin
          if (item.data_byte == ffs_pkg::CH_EOL) begin
            phase_nxt      = PH_QUAL;
            qual_count_nxt = '0;
          end
        end
        PH_QUAL: begin
          if (item.data_byte == ffs_pkg::CH_EOL) begin
            hit     = 1'b1;
            verdict = (qual_count_r == read_count_r) ? ffs_pkg::V_FASTQ : ffs_pkg::V_NONE;
          end else begin
            qual_count_nxt = sat_inc(qual_count_r);
          end
        end
        default: begin
        end
      endcase
    end

    // The buffer ends with no decision yet: judge it by where it stopped.
    if (!hit && item.last_byte && phase_nxt != PH_IDLE) begin
      hit = 1'b1;
      case (phase_nxt)
        PH_READ: verdict = expect_quals_nxt ? ffs_pkg::V_CUT : ffs_pkg::V_NONE;
        PH_QUAL: verdict = (qual_count_nxt == read_count_nxt) ?
                           ffs_pkg::V_FASTQ : ffs_pkg::V_NONE;
        default: verdict = ffs_pkg::V_NONE;
      endcase
    end

    if (hit) begin
      phase_nxt = PH_IDLE;
    end
  end

  assign res.valid   = step && hit;
  assign res.verdict = verdict;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      expect_quals_r <= 1'b0;
      read_count_r   <= '0;
      qual_count_r   <= '0;
    end else if (step) begin
      phase_r        <= phase_nxt;
      expect_quals_r <= expect_quals_nxt;
      read_count_r   <= read_count_nxt;
      qual_count_r   <= qual_count_nxt;
    end
  end

  a_idle_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |=> phase_r == PH_IDLE)
    else $error("detection still running after a verdict");

  a_counts_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(read_count_r) && $stable(qual_count_r) && $stable(phase_r))
    else $error("state moved without a word being processed");

  a_verdict_range: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> res.verdict <= ffs_pkg::V_CUT)
    else $error("verdict code out of range");

  a_qual_only_fastq: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_REMARK || phase_r == PH_QUAL) |-> expect_quals_r)
    else $error("quality phase reached without an '@' tag");

endmodule
